// ----- sv/tks_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the top-K sorted insert block
// Item layouts, cell link records and list depth.
// ----------------------------------------------------------------------------
package tks_pkg;

	localparam int LIST_DEPTH = 8;
	localparam int COUNT_W    = 16;
	localparam int TAG_W      = 16;
	localparam int SLOT_W     = 3;
	localparam int RD_SLOTS   = (LIST_DEPTH < 8) ? LIST_DEPTH : 8;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	typedef struct packed {
		logic               action;
		logic [COUNT_W-1:0] new_count;
		logic [TAG_W-1:0]   new_tag;
		logic [SLOT_W-1:0]  read_slot;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] out_count;
		logic [TAG_W-1:0]   out_tag;
		logic               out_valid;
		logic               was_kept;
		logic [SLOT_W-1:0]  placed_at;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TAG_W-1:0]   tag;
	} rec_t;

	typedef struct packed {
		logic ins;
		rec_t rec;
	} cell_cmd_t;

	typedef struct packed {
		rec_t rec;
		logic lt;
	} cell_link_t;

endpackage
`default_nettype wire

// ----- sv/tks_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_cell: one slot of the sorted list
// Compares its count against the new record, then takes the new record, the
// record from the slot above, or holds.
// ----------------------------------------------------------------------------
module tks_cell import tks_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  cell_cmd_t  cmd,
	input  cell_link_t up,
	output cell_link_t down,
	output logic       first
);

	rec_t rec_q;
	logic lt;

	assign lt        = rec_q.count < cmd.rec.count;
	assign first     = lt && !up.lt;
	assign down.rec  = rec_q;
	assign down.lt   = lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (cmd.ins) begin
			if (up.lt) begin
				rec_q <= up.rec;
			end else if (lt) begin
				rec_q <= cmd.rec;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/top_k_sorted_insert.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_sorted_insert: top-K list of records kept in decreasing count order
// Row of slot cells with a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_item carry one item: an insert (action 0) of a
//   count and tag, or a read (action 1) of one slot.
//   res_valid/res_ready/res_item return exactly one result per item.
//   Every cell compares its count against the new count in the same cycle;
//   the first cell holding a smaller count takes the new record and the
//   cells below take the record of their upper neighbor.
//   The result is registered in res_q when the item is accepted.
//   One item per cycle is accepted while the receiver keeps res_ready high.
//   While a result waits, a new item is still accepted if res_ready is high
//   in the same cycle; when the receiver stalls, in_ready drops until the
//   waiting result is taken.
//   Reset clears every slot to count zero and tag zero (empty) and drops
//   any pending result.
// ----------------------------------------------------------------------------
module top_k_sorted_insert import tks_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      res_valid,
	input  wire       res_ready,
	output out_item_t res_item
);

	cell_cmd_t  cmd;
	cell_link_t links [LIST_DEPTH+1];
	logic       first [LIST_DEPTH];
	logic       accept;
	out_item_t  res_d;
	out_item_t  res_q;
	logic       res_valid_q;

	assign in_ready    = !res_valid_q || res_ready;
	assign accept      = in_valid && in_ready;
	assign cmd.ins     = accept && (in_item.action == ACT_INSERT);
	assign cmd.rec.count = in_item.new_count;
	assign cmd.rec.tag   = in_item.new_tag;
	assign links[0]    = '0;

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		tks_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.up     (links[g]),
			.down   (links[g+1]),
			.first  (first[g])
		);
	end

	always_comb begin
		res_d = '0;
		if (in_item.action == ACT_READ) begin
			for (int i = 0; i < RD_SLOTS; i++) begin
				if (in_item.read_slot == SLOT_W'(i)) begin
					res_d.out_count = links[i+1].rec.count;
					res_d.out_tag   = links[i+1].rec.tag;
					res_d.out_valid = links[i+1].rec.count != '0;
				end
			end
		end else begin
			res_d.was_kept = links[LIST_DEPTH].lt;
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if (first[i]) begin
					res_d.placed_at = res_d.placed_at | SLOT_W'(i);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

`ifndef SYNTH
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		links[1].rec.count >= links[2].rec.count)
		else $error("slots out of order");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.out_valid == (res_item.out_count != '0)))
		else $error("out_valid does not match count");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid)
		else $error("input stalled without pending result");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_item.was_kept && res_item.out_valid))
		else $error("result mixes insert and read fields");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_top_k_sorted_insert.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_sorted_insert: self-checking bench for the top-K sorted insert block
// Inserts and reads flow through a valid/ready driver. A local copy of the
// slot list predicts every result as an item is accepted, and the monitor
// checks every field of each returned result against the oldest prediction.
// A directed opening covers empty reads, zero counts, ties, a full list and
// dropped records. A rising-count random stream follows. Both sides stall
// at random.
// ----------------------------------------------------------------------------
module tb_top_k_sorted_insert import tks_pkg::*; ();

	localparam int RANDOM_ITEMS = 1030;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	out_item_t res_item;

	in_item_t  pending_items[$];
	out_item_t expected_results[$];
	logic [COUNT_W-1:0] list_count [LIST_DEPTH];
	logic [TAG_W-1:0]   list_tag [LIST_DEPTH];
	int total_items = 0;
	int accepted_items = 0;
	int mismatches = 0;
	int cycle_count = 0;

	top_k_sorted_insert DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always #5 clk = ~clk;

	// apply one item to the local slot list and return its result
	function automatic out_item_t topk_apply(in_item_t item);
		out_item_t res;
		int pos;
		res = '0;
		if (item.action == ACT_READ) begin
			if (int'(item.read_slot) < LIST_DEPTH) begin
				res.out_count = list_count[item.read_slot];
				res.out_tag   = list_tag[item.read_slot];
				res.out_valid = (list_count[item.read_slot] != '0);
			end
			return res;
		end
		if (item.new_count == '0)
			return res;
		pos = LIST_DEPTH;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (list_count[i] < item.new_count) begin
				pos = i;
				break;
			end
		end
		if (pos < LIST_DEPTH) begin
			for (int i = LIST_DEPTH - 1; i > pos; i--) begin
				list_count[i] = list_count[i-1];
				list_tag[i]   = list_tag[i-1];
			end
			list_count[pos] = item.new_count;
			list_tag[pos]   = item.new_tag;
			res.was_kept    = 1'b1;
			res.placed_at   = pos[SLOT_W-1:0];
		end
		return res;
	endfunction

	// stall now and then, but never inside the quiet window of each period
	function automatic bit take_break();
		if ((cycle_count % 3000) < 700)
			return 1'b0;
		return ($urandom_range(99) < 20);
	endfunction

	function automatic in_item_t make_insert(int count, int tag);
		in_item_t item;
		item.action    = ACT_INSERT;
		item.new_count = count[COUNT_W-1:0];
		item.new_tag   = tag[TAG_W-1:0];
		item.read_slot = SLOT_W'($urandom_range(7));
		return item;
	endfunction

	function automatic in_item_t make_read(int slot);
		in_item_t item;
		item.action    = ACT_READ;
		item.new_count = COUNT_W'($urandom_range(65535));
		item.new_tag   = TAG_W'($urandom_range(65535));
		item.read_slot = slot[SLOT_W-1:0];
		return item;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(topk_apply(in_item));
				accepted_items++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && !take_break()) begin
					in_item  <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			res_ready <= !take_break();
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: count %0d tag %0d valid %0b kept %0b at %0d",
						res_item.out_count, res_item.out_tag, res_item.out_valid,
						res_item.was_kept, res_item.placed_at);
			end else begin
				want = expected_results.pop_front();
				if (res_item !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"mismatch: expected count %0d tag %0d valid %0b kept %0b",
							" at %0d, got count %0d tag %0d valid %0b kept %0b at %0d"},
							want.out_count, want.out_tag, want.out_valid, want.was_kept,
							want.placed_at, res_item.out_count, res_item.out_tag,
							res_item.out_valid, res_item.was_kept, res_item.placed_at);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		in_item_t item;
		int last_count;
		int count;
		int pick;

		for (int i = 0; i < LIST_DEPTH; i++) begin
			list_count[i] = '0;
			list_tag[i]   = '0;
		end

		// empty list, zero count, ties, full list, dropped records
		pending_items.push_back(make_read(0));
		pending_items.push_back(make_read(7));
		pending_items.push_back(make_insert(0, 16'h1111));
		pending_items.push_back(make_insert(100, 16'h000a));
		pending_items.push_back(make_insert(100, 16'h000b));
		pending_items.push_back(make_insert(65535, 16'hffff));
		pending_items.push_back(make_insert(1, 16'h0001));
		pending_items.push_back(make_insert(50, 16'h0050));
		pending_items.push_back(make_insert(200, 16'h0200));
		pending_items.push_back(make_insert(100, 16'h000c));
		pending_items.push_back(make_insert(65535, 16'h0000));
		pending_items.push_back(make_insert(1, 16'h5555));
		pending_items.push_back(make_insert(2, 16'haaaa));
		pending_items.push_back(make_insert(2, 16'h2222));
		pending_items.push_back(make_insert(65535, 16'h7777));
		for (int s = 0; s < 8; s++)
			pending_items.push_back(make_read(s));

		// rising counts keep the list turning over; ties, drops and extremes mixed in
		last_count = 1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(99) < 45) begin
				item = make_read($urandom_range(7));
			end else begin
				pick = $urandom_range(99);
				if (pick < 4)
					count = 0;
				else if (pick < 8)
					count = 65535;
				else if (pick < 22)
					count = last_count;
				else if (pick < 32)
					count = $urandom_range(65535);
				else begin
					count = i * 63 + $urandom_range(400);
					if (count > 65535)
						count = 65535 - $urandom_range(300);
				end
				if (count != 0)
					last_count = count;
				item = make_insert(count, $urandom_range(65535));
			end
			pending_items.push_back(item);
		end
		total_items = pending_items.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_items < total_items)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
